// ===== sv/rhn_pkg.sv =====
package rhn_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int NUM_BINS    = 256;
  localparam int BIN_BITS    = $clog2(NUM_BINS);
  localparam int NUM_CH      = 3;
  localparam int OP_BITS     = 2;

  // level = floor(count * FULL_SCALE / peak), units of 1/256 percent
  localparam int FULL_SCALE  = 25600;
  localparam int LEVEL_BITS  = 15;
  localparam int PROD_BITS   = COUNT_BITS + LEVEL_BITS;
  localparam int STEP_BITS   = $clog2(LEVEL_BITS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int S_DATA_BITS = ((NUM_CH * BIN_BITS + BIN_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = ((NUM_CH * LEVEL_BITS + 7) / 8) * 8;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [BIN_BITS-1:0]   bin_t;
  typedef logic [PROD_BITS-1:0]  prod_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_ADD,
    K_READ
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUMP,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

  // one queued operation; addr holds the bin per channel (red, green, blue)
  typedef struct packed {
    kind_e                   kind;
    bin_t [NUM_CH-1:0]       addr;
  } qitem_t;

  typedef struct packed {
    logic rd;
    logic upd;
    logic clr;
  } chan_ctrl_t;

endpackage

// ===== sv/rgb_histogram_normalized_core.sv =====
// Three 256-bin histograms (red, green, blue) with a running peak per channel.
// tuser selects the operation: clear all bins and peaks, add one pixel, read
// one bin as count * 25600 / peak (rounded down, zero when the peak is zero),
// or drop the unused code. A four-entry queue sits behind the input, so the
// source keeps streaming until the queue is full while the back end works.
// The back end takes one queued operation at a time: a clear acts on pop, a
// pixel reads then writes the bin memories, and a bin read goes through read,
// multiply, load, 15 steps of a restoring divider (one per quotient bit) and
// the output state, plus any wait on m_axis_tready. Bin memories need no
// clearing pass: per-bin valid bits are wiped by reset or a clear.
module rgb_histogram_normalized_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], bin [31:24]
  input  logic [rhn_pkg::S_DATA_BITS-1:0]   s_axis_tdata,
  // op [1:0]
  input  logic [rhn_pkg::OP_BITS-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // red_level [14:0], green_level [29:15], blue_level [44:30], zero [47:45]
  output logic [rhn_pkg::M_DATA_BITS-1:0]   m_axis_tdata
);
  import rhn_pkg::*;

  logic   q_valid, q_pop;
  qitem_t q_item;

  rhn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  rhn_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

// ===== sv/rhn_front.sv =====
module rhn_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [rhn_pkg::S_DATA_BITS-1:0]   s_tdata_i,
  input  logic [rhn_pkg::OP_BITS-1:0]       s_tuser_i,
  output logic                              q_valid_o,
  output rhn_pkg::qitem_t                   q_item_o,
  input  logic                              q_pop_i
);
  import rhn_pkg::*;

  localparam logic [QPTR_BITS:0] QCNT_FULL = (QPTR_BITS+1)'(QUEUE_DEPTH);

  qitem_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_BITS:0]   cnt_q, cnt_d;
  logic                 accept, push, pop;
  op_e                  op;
  qitem_t               item;

  assign s_tready_o = (cnt_q != QCNT_FULL);
  assign accept     = s_tvalid_i && s_tready_o;
  assign op         = op_e'(s_tuser_i);

  // classify: unused op code is taken and dropped
  always_comb begin
    item.kind = K_CLEAR;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      item.addr[ch] = s_tdata_i[ch*BIN_BITS +: BIN_BITS];
    end
    push = 1'b0;
    unique case (op)
      OP_CLEAR: begin
        item.kind = K_CLEAR;
        push      = accept;
      end
      OP_ADD: begin
        item.kind = K_ADD;
        push      = accept;
      end
      OP_READ: begin
        item.kind = K_READ;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          item.addr[ch] = s_tdata_i[NUM_CH*BIN_BITS +: BIN_BITS];
        end
        push = accept;
      end
      OP_NOP: begin
        push = 1'b0;
      end
    endcase
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = queue_q[rd_ptr_q];
  assign pop       = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_FULL)
    else $error("queue count beyond depth");

  a_nop_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_NOP && !pop) |=> cnt_q == $past(cnt_q))
    else $error("unused op code entered the queue");
`endif

endmodule

// ===== sv/rhn_chan.sv =====
module rhn_chan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rhn_pkg::chan_ctrl_t  ctrl_i,
  input  rhn_pkg::bin_t        addr_i,
  output rhn_pkg::count_t      count_o,
  output rhn_pkg::count_t      peak_o
);
  import rhn_pkg::*;

  localparam count_t CNT_MAX = '1;

  count_t              mem_q [NUM_BINS];
  logic [NUM_BINS-1:0] vld_q;
  count_t              rd_data_q;
  logic                rd_vld_q;
  count_t              peak_q;
  count_t              bump;

  // entries not written since the last clear read as zero
  assign count_o = rd_vld_q ? rd_data_q : '0;
  assign bump    = (count_o == CNT_MAX) ? count_o : count_o + 1'b1;
  assign peak_o  = peak_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_data_q <= mem_q[addr_i];
    end
    if (ctrl_i.upd) begin
      mem_q[addr_i] <= bump;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      peak_q   <= '0;
    end else begin
      if (ctrl_i.clr) begin
        vld_q  <= '0;
        peak_q <= '0;
      end else if (ctrl_i.upd) begin
        vld_q[addr_i] <= 1'b1;
        if (bump > peak_q) begin
          peak_q <= bump;
        end
      end
      if (ctrl_i.rd) begin
        rd_vld_q <= vld_q[addr_i];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.upd |=> peak_q >= $past(bump))
    else $error("peak below a freshly written count");
`endif

endmodule

// ===== sv/rhn_div.sv =====
module rhn_div (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             step_i,
  input  rhn_pkg::prod_t   dividend_i,
  input  rhn_pkg::count_t  divisor_i,
  output rhn_pkg::level_t  quot_o
);
  import rhn_pkg::*;

  // restoring division, one quotient bit per step; quotient fits LEVEL_BITS
  // because count <= peak, so the upper dividend bits start below the divisor
  count_t            rem_q, div_q;
  level_t            sh_q;
  logic [COUNT_BITS:0] trial, diff;
  logic              ge;

  assign trial  = {rem_q, sh_q[LEVEL_BITS-1]};
  assign diff   = trial - {1'b0, div_q};
  assign ge     = (trial >= {1'b0, div_q});
  assign quot_o = sh_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= dividend_i[PROD_BITS-1:LEVEL_BITS];
      sh_q  <= dividend_i[LEVEL_BITS-1:0];
      div_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      sh_q  <= {sh_q[LEVEL_BITS-2:0], ge};
    end
  end

endmodule

// ===== sv/rhn_back.sv =====
module rhn_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  rhn_pkg::qitem_t                   q_item_i,
  output logic                              q_pop_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [rhn_pkg::M_DATA_BITS-1:0]   m_tdata_o
);
  import rhn_pkg::*;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(LEVEL_BITS - 1);
  localparam prod_t                SCALE     = PROD_BITS'(FULL_SCALE);

  state_e                  state_q, state_d;
  qitem_t                  cur_q;
  prod_t                   prod_q [NUM_CH];
  logic [STEP_BITS-1:0]    step_q;
  logic                    out_vld_q;
  logic [M_DATA_BITS-1:0]  out_data_q, out_data_d;

  chan_ctrl_t              chan_ctrl;
  logic                    div_load, div_step, out_load;
  bin_t                    addr   [NUM_CH];
  count_t                  count  [NUM_CH];
  count_t                  peak   [NUM_CH];
  level_t                  quot   [NUM_CH];
  level_t                  level  [NUM_CH];

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    // read address comes straight from the queue head when it is popped
    assign addr[ch]  = (state_q == ST_IDLE) ? q_item_i.addr[ch] : cur_q.addr[ch];
    assign level[ch] = (peak[ch] == '0) ? '0 : quot[ch];

    rhn_chan u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (chan_ctrl),
      .addr_i  (addr[ch]),
      .count_o (count[ch]),
      .peak_o  (peak[ch])
    );

    rhn_div u_div (
      .clk_i      (clk_i),
      .load_i     (div_load),
      .step_i     (div_step),
      .dividend_i (prod_q[ch]),
      .divisor_i  (peak[ch]),
      .quot_o     (quot[ch])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          unique case (q_item_i.kind)
            K_ADD:   state_d = ST_BUMP;
            K_READ:  state_d = ST_MUL;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_BUMP: state_d = ST_IDLE;
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == LAST_STEP) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || m_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o       = (state_q == ST_IDLE) && q_valid_i;
    chan_ctrl.rd  = q_pop_o && (q_item_i.kind != K_CLEAR);
    chan_ctrl.clr = q_pop_o && (q_item_i.kind == K_CLEAR);
    chan_ctrl.upd = (state_q == ST_BUMP);
    div_load      = (state_q == ST_LOAD);
    div_step      = (state_q == ST_DIV);
    out_load      = (state_q == ST_OUT) && (!out_vld_q || m_tready_i);
  end

  always_comb begin
    out_data_d = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      out_data_d[ch*LEVEL_BITS +: LEVEL_BITS] = level[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_load) begin
        step_q <= '0;
      end else if (div_step) begin
        step_q <= step_q + 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_item_i;
    end
    if (state_q == ST_MUL) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        prod_q[ch] <= PROD_BITS'(count[ch]) * SCALE;
      end
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_bump_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_ctrl.upd |-> $past(chan_ctrl.rd))
    else $error("bin update without a preceding read");

  a_out_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT || state_q == ST_DIV) |-> cur_q.kind == K_READ)
    else $error("division running for a non-read operation");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (level[0] <= LEVEL_BITS'(FULL_SCALE)) &&
                 (level[1] <= LEVEL_BITS'(FULL_SCALE)) &&
                 (level[2] <= LEVEL_BITS'(FULL_SCALE)))
    else $error("level above full scale");
`endif

endmodule

// ===== verif/tb_rgb_histogram_normalized_core.sv =====
module tb_rgb_histogram_normalized_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rhn_pkg::*;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 100;

  typedef level_t [NUM_CH-1:0] levels_t;  // red in element 0

  typedef struct packed {
    op_e        op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bin;
    logic       hold;   // wait for every pending level before sending
    logic       typed;  // levels below are the expected read result
    level_t     red_lv;
    level_t     green_lv;
    level_t     blue_lv;
  } stim_t;

  // op, red, green, blue, bin, hold, typed, red_lv, green_lv, blue_lv
  localparam stim_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_READ,    0,   0,   0,   0, 0, 1,     0,     0,     0},
    '{OP_READ,    0,   0,   0, 255, 0, 1,     0,     0,     0},
    '{OP_NOP,   255, 255, 255, 255, 0, 0,     0,     0,     0},
    '{OP_ADD,     0, 255,   0, 255, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0,   0, 0, 1, 25600,     0, 25600},
    '{OP_READ,  255, 255, 255, 255, 0, 1,     0, 25600,     0},
    '{OP_ADD,   255, 255,   0,   0, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0, 255, 0, 1, 25600, 25600,     0},
    '{OP_ADD,     0,   0,   0,   0, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0,   0, 0, 0,     0,     0,     0},
    '{OP_ADD,     0,   0,   0,   0, 0, 0,     0,     0,     0},
    '{OP_ADD,     0,   0,   0,   0, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0, 255, 0, 0,     0,     0,     0},
    '{OP_ADD,   170,  85, 170,  85, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0, 170, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0,  85, 0, 0,     0,     0,     0},
    '{OP_CLEAR,   0,   0,   0,   0, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0,   0, 0, 1,     0,     0,     0},
    '{OP_ADD,     1,   2,   4,   8, 0, 0,     0,     0,     0},
    '{OP_ADD,     2,   2,   2,  64, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0,   2, 0, 0,     0,     0,     0},
    '{OP_CLEAR, 255, 255, 255, 255, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0, 255, 0, 1,     0,     0,     0},
    '{OP_NOP,     0,   0,   0,   0, 0, 0,     0,     0,     0},
    '{OP_READ,    0,   0,   0,   0, 0, 1,     0,     0,     0}
  };

  localparam string CH_NAME [NUM_CH] = '{"red", "green", "blue"};

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_DATA_BITS-1:0] s_axis_tdata  = '0;
  logic [OP_BITS-1:0]     s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_axis_tdata;

  rgb_histogram_normalized_core DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predicted histogram state, channel order red, green, blue
  count_t  hist [NUM_CH][NUM_BINS];
  count_t  peak [NUM_CH];
  levels_t pending_levels [$];
  stim_t   stim [$];

  int n_errors  = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_full    = 0;
  int op_count [4] = '{0, 0, 0, 0};

  function automatic count_t saturating_inc(count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic level_t scaled_level(count_t cnt, count_t pk);
    longint unsigned prod;
    if (pk == '0) return '0;
    prod = longint'(cnt) * FULL_SCALE;
    return level_t'(prod / pk);
  endfunction

  function automatic stim_t row(op_e op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [7:0] bin_idx, logic hold);
    stim_t s;
    s       = '0;
    s.op    = op;
    s.red   = r;
    s.green = g;
    s.blue  = b;
    s.bin   = bin_idx;
    s.hold  = hold;
    return s;
  endfunction

  // receiver: always ready, light random stalls, periodic long stalls, coin flips
  logic [8:0] rx_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase      <= '0;
      m_axis_tready <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 1'b1;
      case (rx_phase[8:7])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2'd2: m_axis_tready <= (rx_phase[3:0] >= 4'd10);
        default: m_axis_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk_i) begin : scoreboard
    logic [7:0] px [NUM_CH];
    logic [7:0] bin_idx;
    op_e        op;
    levels_t    want;
    levels_t    got;
    logic       moved;
    int         stalled;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        moved   = 1'b1;
        px[0]   = s_axis_tdata[7:0];
        px[1]   = s_axis_tdata[15:8];
        px[2]   = s_axis_tdata[23:16];
        bin_idx = s_axis_tdata[31:24];
        op      = op_e'(s_axis_tuser);
        op_count[s_axis_tuser]++;
        case (op)
          OP_CLEAR: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
              peak[ch] = '0;
              for (int i = 0; i < NUM_BINS; i++) hist[ch][i] = '0;
            end
          end
          OP_ADD: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
              hist[ch][px[ch]] = saturating_inc(hist[ch][px[ch]]);
              if (hist[ch][px[ch]] > peak[ch]) peak[ch] = hist[ch][px[ch]];
            end
          end
          OP_READ: begin
            for (int ch = 0; ch < NUM_CH; ch++)
              want[ch] = scaled_level(hist[ch][bin_idx], peak[ch]);
            if (stim[n_sent].typed)
              want = {stim[n_sent].blue_lv, stim[n_sent].green_lv, stim[n_sent].red_lv};
            pending_levels.push_back(want);
          end
          OP_NOP: ;
        endcase
        n_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got   = m_axis_tdata[NUM_CH*LEVEL_BITS-1:0];
        if (pending_levels.size() == 0) begin
          $error("result with no read pending: tdata 0x%0h", m_axis_tdata);
          n_errors++;
        end else begin
          want = pending_levels.pop_front();
          n_checked++;
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (got[ch] != want[ch]) begin
              $error("%s_level: expected %0d, got %0d", CH_NAME[ch], want[ch], got[ch]);
              n_errors++;
            end
            if (want[ch] == level_t'(FULL_SCALE)) n_full++;
          end
          if (m_axis_tdata[M_DATA_BITS-1:NUM_CH*LEVEL_BITS] != '0) begin
            $error("zero: expected 0, got %0d", m_axis_tdata[M_DATA_BITS-1:NUM_CH*LEVEL_BITS]);
            n_errors++;
          end
        end
      end
      // watchdog on cycles where neither side moves a transaction
      stalled = moved ? 0 : stalled + 1;
      if (stalled >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles, %0d reads outstanding",
                 STALL_LIMIT, pending_levels.size());
        $display("FAIL rgb_histogram_normalized_core");
        $finish;
      end
    end else begin
      stalled = 0;
    end
  end

  initial begin : stimulus
    logic [7:0] base [NUM_CH];
    logic [7:0] mask [NUM_CH];
    logic [7:0] px [NUM_CH];
    logic [7:0] bin_idx;
    logic       first;
    int         sel;
    int         burst_left;
    int         gap;

    for (int ch = 0; ch < NUM_CH; ch++) begin
      peak[ch] = '0;
      for (int i = 0; i < NUM_BINS; i++) hist[ch][i] = '0;
    end

    for (int i = 0; i < DIRECTED_ROWS; i++) stim.push_back(DIRECTED[i]);

    // frames: maybe a clear, pixels/reads/nops in narrow/wide windows, then bin reads
    while (stim.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
      first = (stim.size() == DIRECTED_ROWS);
      if (first || $urandom_range(0, 4) != 0)
        stim.push_back(row(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           first || $urandom_range(0, 3) == 0));
      for (int ch = 0; ch < NUM_CH; ch++) begin
        base[ch] = 8'($urandom);
        case ($urandom_range(0, 3))
          0: mask[ch] = 8'h00;
          1: mask[ch] = 8'h03;
          2: mask[ch] = 8'h0f;
          default: mask[ch] = 8'hff;
        endcase
      end
      repeat ($urandom_range(8, 120)) begin
        sel = $urandom_range(0, 39);
        for (int ch = 0; ch < NUM_CH; ch++) px[ch] = base[ch] + (8'($urandom) & mask[ch]);
        if (sel == 0)
          stim.push_back(row(OP_NOP, px[0], px[1], px[2], 8'($urandom), 1'b0));
        else if (sel < 5)
          stim.push_back(row(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), px[sel % 3],
                             1'b0));
        else
          stim.push_back(row(OP_ADD, px[0], px[1], px[2], 8'($urandom), 1'b0));
      end
      repeat ($urandom_range(4, 20)) begin
        sel = $urandom_range(0, 3);
        if (sel == 3) bin_idx = 8'($urandom);
        else bin_idx = base[sel] + (8'($urandom) & mask[sel]);
        stim.push_back(row(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), bin_idx, 1'b0));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = 0;
    for (int k = 0; k < stim.size(); k++) begin
      if (stim[k].hold) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_levels.size() != 0) @(posedge clk_i);
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {stim[k].bin, stim[k].blue, stim[k].green, stim[k].red};
      s_axis_tuser  <= stim[k].op;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      burst_left--;
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending_levels.size() != 0) @(posedge clk_i);
    // let trailing pixel and clear transactions drain out of the queue
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d transactions: %0d clears, %0d pixels, %0d bin reads, %0d unused ops",
             n_sent, op_count[OP_CLEAR], op_count[OP_ADD], op_count[OP_READ], op_count[OP_NOP]);
    $display("checked %0d normalized bin reads, %0d channel levels at full scale",
             n_checked, n_full);
    if (n_errors == 0) begin
      $display("PASS rgb_histogram_normalized_core");
    end else begin
      $display("FAIL rgb_histogram_normalized_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rhn_pkg.sv
sv/rhn_front.sv
sv/rhn_chan.sv
sv/rhn_div.sv
sv/rhn_back.sv
sv/rgb_histogram_normalized_core.sv
verif/tb_rgb_histogram_normalized_core.sv
